// ===== rtl/dsfr_pkg.sv =====
// Shared types and constants for the display serial frame receiver.
package dsfr_pkg;

   // Frame positions and lengths (length byte plus three fits in nine bits)
   localparam int POS_W = 9;
   // Element counts per frame
   localparam int CNT_W = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 1'd1;

   localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
   localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;

   localparam logic [7:0] CMD_REG_WRITE = 8'h80;
   localparam logic [7:0] CMD_REG_READ  = 8'h81;
   localparam logic [7:0] CMD_VAR_WRITE = 8'h82;
   localparam logic [7:0] CMD_VAR_READ  = 8'h83;
   localparam logic [7:0] ACK_O         = 8'h4F;
   localparam logic [7:0] ACK_K         = 8'h4B;
   localparam logic [7:0] FRAME_OVERHEAD = 8'h03;

   localparam logic [2:0] KIND_REG_OK   = 3'd0;
   localparam logic [2:0] KIND_VAR_OK   = 3'd1;
   localparam logic [2:0] KIND_VAR_READ = 3'd2;
   localparam logic [2:0] KIND_REG_READ = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   // Decoded frame handed from the collector to the emitter
   typedef struct packed {
      logic [2:0]       kind;
      logic [15:0]      addr;
      logic [7:0]       count;
      logic [CNT_W-1:0] elems;
      logic             word;
      logic [POS_W-1:0] total;
   } job_type;

   typedef struct packed {
      logic [2:0]  frame_kind;
      logic [15:0] target_address;
      logic [7:0]  payload_bytes;
      logic        has_data;
      logic [15:0] data_value;
      logic        last_of_frame;
   } rsp_type;

endpackage

// ===== rtl/dsfr_if.sv =====
// Valid/ready channel interfaces for received bytes and decoded results.
interface dsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_kind;
   logic [15:0] target_address;
   logic [7:0]  payload_bytes;
   logic        has_data;
   logic [15:0] data_value;
   logic        last_of_frame;

   modport source (output valid, output frame_kind, output target_address,
                   output payload_bytes, output has_data, output data_value,
                   output last_of_frame, input ready);
   modport sink (input valid, input frame_kind, input target_address,
                 input payload_bytes, input has_data, input data_value,
                 input last_of_frame, output ready);
endinterface

// ===== rtl/display_serial_frame_receiver.sv =====
// Top level: serial display frame receiver.
//
//   channel | direction | carries
//   --------+-----------+---------------------------------------------------
//   req_if  | in        | one received byte per transfer
//   rsp_if  | out       | decoded result: kind, address, count, data, last
//   csr_*   | in        | header byte writes, index 0 first, 1 second
//
// A completed frame that yields a result holds req_if.ready low while it is
// handed to the emitter and results go out: a single result goes straight out,
// each register-read byte passes the read, latch and output states and each
// variable-read word a second read for its low byte too, set by the single
// read port of the frame memory. Reset is synchronous and needs no clearing
// pass; reads past the current frame are masked to zero. A stalled rsp_if
// holds the emitter in place; bytes resume once the last result is loaded.
module display_serial_frame_receiver import dsfr_pkg::*; #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   dsfr_req_if.sink             req_if,
   dsfr_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wr_data
);

   localparam int AW = $clog2(FRAME_BYTES);

   logic          busy, byte_take;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic          job_valid;
   job_type       job;
   rsp_type       rsp;

   assign req_if.ready = !busy;
   assign byte_take    = req_if.valid && !busy;

   dsfr_collector #(.FRAME_BYTES(FRAME_BYTES)) u_collector (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .byte_take   (byte_take),
      .byte_data   (req_if.rx_byte),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .job_valid   (job_valid),
      .job         (job)
   );

   dsfr_frame_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dsfr_emitter #(.FRAME_BYTES(FRAME_BYTES)) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp       (rsp)
   );

   assign rsp_if.frame_kind     = rsp.frame_kind;
   assign rsp_if.target_address = rsp.target_address;
   assign rsp_if.payload_bytes  = rsp.payload_bytes;
   assign rsp_if.has_data       = rsp.has_data;
   assign rsp_if.data_value     = rsp.data_value;
   assign rsp_if.last_of_frame  = rsp.last_of_frame;

endmodule

// ===== rtl/dsfr_frame_store.sv =====
// Frame byte memory: one write port, one registered read port.
module dsfr_frame_store #(
   parameter int FRAME_BYTES = 64,
   localparam int AW = $clog2(FRAME_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dsfr_collector.sv =====
// Byte collector: header check, length tracking and frame decode.
module dsfr_collector import dsfr_pkg::*; #(
   parameter int FRAME_BYTES = 64,
   localparam int AW = $clog2(FRAME_BYTES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wr_data,
   input  logic                 byte_take,
   input  logic [7:0]           byte_data,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [7:0]           wr_data,
   output logic                 job_valid,
   output job_type              job
);

   localparam logic [POS_W-1:0] FRAME_MAX = POS_W'(FRAME_BYTES);
   localparam logic [CNT_W-1:0] LIM_BYTES = CNT_W'(FRAME_BYTES - 6);
   localparam logic [CNT_W-1:0] LIM_WORDS = CNT_W'((FRAME_BYTES - 6) / 2);

   logic [7:0]    hdr_first_ff, hdr_second_ff;
   logic [AW-1:0] held_ff, held_in;
   logic [7:0]    b0_ff, b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff;
   logic          job_valid_ff, job_valid_in;
   job_type       job_ff, job_in;

   logic [POS_W-1:0] pos, held_next, total;
   logic [7:0]       byte0, len, cmd, a4, a5, a6;
   logic [CNT_W:0]   words_full;
   logic [CNT_W-1:0] words, bytes_n;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HEADER_FIRST_RST;
         hdr_second_ff <= HEADER_SECOND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEADER_FIRST:  hdr_first_ff  <= csr_wr_data;
            CSR_HEADER_SECOND: hdr_second_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Forward the incoming byte for whichever header field it completes
   always_comb begin
      pos       = POS_W'(held_ff);
      held_next = pos + POS_W'(1);
      byte0     = (pos == POS_W'(0)) ? byte_data : b0_ff;
      len       = (pos == POS_W'(2)) ? byte_data : b2_ff;
      total     = POS_W'(len) + POS_W'(FRAME_OVERHEAD);
      cmd = (total > POS_W'(3)) ? ((pos == POS_W'(3)) ? byte_data : b3_ff) : 8'h00;
      a4  = (total > POS_W'(4)) ? ((pos == POS_W'(4)) ? byte_data : b4_ff) : 8'h00;
      a5  = (total > POS_W'(5)) ? ((pos == POS_W'(5)) ? byte_data : b5_ff) : 8'h00;
      a6  = (total > POS_W'(6)) ? ((pos == POS_W'(6)) ? byte_data : b6_ff) : 8'h00;
      words_full = (9'(a6) + 9'd1) >> 1;
      words   = (words_full > 9'(LIM_WORDS)) ? LIM_WORDS : words_full[CNT_W-1:0];
      bytes_n = (a5 > LIM_BYTES) ? LIM_BYTES : a5;
   end

   always_comb begin
      held_in       = held_ff;
      job_valid_in  = 1'b0;
      job_in        = '0;
      job_in.total  = total;
      if (byte_take) begin
         if (byte0 != hdr_first_ff) begin
            held_in = '0;
         end else if (held_next < POS_W'(3)) begin
            held_in = held_next[AW-1:0];
         end else if (total > FRAME_MAX) begin
            held_in      = '0;
            job_valid_in = 1'b1;
            job_in.kind  = KIND_ERROR;
         end else if (held_next != total) begin
            held_in = held_next[AW-1:0];
         end else begin
            held_in = '0;
            if (b1_ff != hdr_second_ff) begin
               job_valid_in = 1'b1;
               job_in.kind  = KIND_ERROR;
            end else if (total == POS_W'(6) &&
                         (cmd == CMD_REG_WRITE || cmd == CMD_VAR_WRITE) &&
                         a4 == ACK_O && a5 == ACK_K) begin
               job_valid_in = 1'b1;
               job_in.kind  = (cmd == CMD_REG_WRITE) ? KIND_REG_OK : KIND_VAR_OK;
            end else if (cmd == CMD_VAR_READ) begin
               job_valid_in = 1'b1;
               job_in.kind  = KIND_VAR_READ;
               job_in.addr  = {a4, a5};
               job_in.count = a6;
               job_in.elems = words;
               job_in.word  = 1'b1;
            end else if (cmd == CMD_REG_READ) begin
               job_valid_in = 1'b1;
               job_in.kind  = KIND_REG_READ;
               job_in.addr  = {8'h00, a4};
               job_in.count = a5;
               job_in.elems = bytes_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         job_valid_ff <= job_valid_in;
      end
   end

   // Header copies kept beside the memory for the decode, and the registered job
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (byte_take) begin
         case (pos)
            POS_W'(0): b0_ff <= byte_data;
            POS_W'(1): b1_ff <= byte_data;
            POS_W'(2): b2_ff <= byte_data;
            POS_W'(3): b3_ff <= byte_data;
            POS_W'(4): b4_ff <= byte_data;
            POS_W'(5): b5_ff <= byte_data;
            POS_W'(6): b6_ff <= byte_data;
            default: ;
         endcase
      end
   end

   assign wr_en     = byte_take;
   assign wr_addr   = held_ff;
   assign wr_data   = byte_data;
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// ===== rtl/dsfr_emitter.sv =====
// Result sequencer: walks the stored payload and drives the result register.
module dsfr_emitter import dsfr_pkg::*; #(
   parameter int FRAME_BYTES = 64,
   localparam int AW = $clog2(FRAME_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   input  job_type       job,
   output logic          busy,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [7:0]    rd_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_HI   = 3'd2;
   localparam logic [2:0] S_LAT  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam logic [POS_W-1:0] FRAME_MAX = POS_W'(FRAME_BYTES);

   logic [2:0]       state_ff, state_in;
   job_type          job_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rd_ok_ff;
   logic [7:0]       hi_ff;
   logic [15:0]      val_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;

   logic       out_free, last, load;
   logic [7:0] data_byte;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last      = (job_ff.elems == '0) ||
                      ({1'b0, cnt_ff} + 9'd1 == {1'b0, job_ff.elems});
   assign load      = (state_ff == S_OUT) && out_free;
   assign data_byte = rd_ok_ff ? rd_data : 8'h00;
   assign rd_en     = (state_ff == S_RD) || (state_ff == S_HI);
   assign rd_addr   = (pos_ff < FRAME_MAX) ? pos_ff[AW-1:0] : '0;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               cnt_in   = '0;
               pos_in   = job.word ? POS_W'(7) : POS_W'(6);
               state_in = (job.elems == '0) ? S_OUT : S_RD;
            end
         end
         S_RD: begin
            pos_in   = pos_ff + POS_W'(1);
            state_in = job_ff.word ? S_HI : S_LAT;
         end
         S_HI: begin
            pos_in   = pos_ff + POS_W'(1);
            state_in = S_LAT;
         end
         S_LAT: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = last ? S_IDLE : S_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      if (rd_en) begin
         rd_ok_ff <= pos_ff < job_ff.total;
      end
      if (state_ff == S_IDLE && job_valid) begin
         job_ff <= job;
         val_ff <= '0;
      end
      if (state_ff == S_LAT) begin
         hi_ff  <= data_byte;
      end
      if (state_ff == S_HI) begin
         hi_ff  <= data_byte;
      end
      if (state_ff == S_LAT) begin
         val_ff <= job_ff.word ? {hi_ff, data_byte} : {8'h00, data_byte};
      end
      if (load) begin
         rsp_ff.frame_kind     <= job_ff.kind;
         rsp_ff.target_address <= job_ff.addr;
         rsp_ff.payload_bytes  <= job_ff.count;
         rsp_ff.has_data       <= job_ff.elems != '0;
         rsp_ff.data_value     <= val_ff;
         rsp_ff.last_of_frame  <= last;
      end
   end

   assign busy      = (state_ff != S_IDLE) || job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
